// ----- rtl/core/mwsl_pkg.sv -----
// Shared constants, register codes and divider handshake types for the wheel speed limiter.
package mwsl_pkg;

  localparam int SPEED_FRAC_BITS = 8;
  localparam int ARM_FRAC_BITS   = 16;

  localparam int VEL_W      = 16;
  localparam int CFG_W      = 16;
  localparam int LIM_W      = 15;
  localparam int WHEEL_W    = 16;
  localparam int IDLE_W     = 17;
  localparam int NUM_WHEELS = 4;
  localparam int WIDX_W     = 2;
  localparam int CFG_IDX_W  = 2;

  localparam int OP_W     = 33;
  localparam int OP_LO_W  = 16;
  localparam int OP_HI_W  = OP_W - OP_LO_W;
  localparam int MUL_B_W  = 16;
  localparam int MUL_P_W  = OP_HI_W + MUL_B_W;
  localparam int LO_P_W   = OP_LO_W + MUL_B_W;
  localparam int PROD_W   = OP_W + MUL_B_W;
  localparam int SHIFT_W  = ARM_FRAC_BITS + SPEED_FRAC_BITS;
  localparam int MAG_W    = PROD_W - SHIFT_W;
  localparam int SX_W     = VEL_W + 1;
  localparam int SUM_W    = OP_W + 1;

  localparam int QUO_W = LIM_W;
  localparam int NUM_W = MAG_W + LIM_W;
  localparam int CNT_W = $clog2(QUO_W + 1);

  localparam logic [CFG_W-1:0]  ARM_RESET     = 16'd20000;
  localparam logic [CFG_W-1:0]  RADIUS_RESET  = 16'd3355;
  localparam logic [LIM_W-1:0]  MAX_RESET     = 15'd12800;
  localparam logic [CFG_W-1:0]  TIMEOUT_RESET = 16'd500;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ARM_LENGTH = 2'd0,
    REG_INV_RADIUS = 2'd1,
    REG_MAX_SPEED  = 2'd2,
    REG_TIMEOUT    = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    CMD_VELOCITY = 1'b0,
    CMD_TICK     = 1'b1
  } cmd_e;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [MAG_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [QUO_W-1:0] quot;
  } div_rsp_t;

endpackage

// ----- rtl/core/mwsl_if.sv -----
// Command and result channel interfaces of the wheel speed limiter.
interface mwsl_cmd_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic signed [15:0] vel_x;
  logic signed [15:0] vel_y;
  logic signed [15:0] yaw_rate;

  modport source (output valid, output cmd, output vel_x, output vel_y, output yaw_rate,
                  input ready);
  modport sink (input valid, input cmd, input vel_x, input vel_y, input yaw_rate,
                output ready);
endinterface

interface mwsl_res_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] wheel_speed_0;
  logic signed [15:0] wheel_speed_1;
  logic signed [15:0] wheel_speed_2;
  logic signed [15:0] wheel_speed_3;
  logic               was_limited;
  logic               timed_out;

  modport source (output valid, output wheel_speed_0, output wheel_speed_1,
                  output wheel_speed_2, output wheel_speed_3, output was_limited,
                  output timed_out, input ready);
  modport sink (input valid, input wheel_speed_0, input wheel_speed_1,
                input wheel_speed_2, input wheel_speed_3, input was_limited,
                input timed_out, output ready);
endinterface

// ----- rtl/core/mecanum_wheel_speed_limiter.sv -----
// Top level of the mecanum wheel speed limiter with a command watchdog.
//
//   channel    | direction | handshake   | contents
//   cmd_chan_i | in        | valid/ready | cmd, vel_x, vel_y, yaw_rate
//   res_chan_o | out       | valid/ready | wheel_speed_0..3, was_limited, timed_out
//   cfg        | in        | cfg_we_i    | cfg_idx_i, cfg_data_i
//
// A tick transaction passes through the tick and done states before its result is valid.
// A velocity command uses one shared 17x16 multiplier to form a*w and then each wheel in
// three steps. When the limit applies, each wheel adds a rescale product and 15 steps
// of the serial divider.
// Reset is asynchronous and active low; no clearing pass is needed after it.
// One transaction is in flight at a time; a finished result waits in the output register.
module mecanum_wheel_speed_limiter (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mwsl_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [mwsl_pkg::CFG_W-1:0]     cfg_data_i,
  mwsl_cmd_if.sink                       cmd_chan_i,
  mwsl_res_if.source                     res_chan_o
);
  import mwsl_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TICK,
    ST_AW,
    ST_SUM,
    ST_MLO,
    ST_MHI,
    ST_PEAK,
    ST_CHECK,
    ST_SLOAD,
    ST_DIV,
    ST_DONE
  } state_e;

  state_e              state_q;
  logic [CFG_W-1:0]    arm_q;
  logic [CFG_W-1:0]    radius_q;
  logic [LIM_W-1:0]    max_q;
  logic [CFG_W-1:0]    timeout_q;

  logic signed [VEL_W-1:0] vx_q;
  logic signed [VEL_W-1:0] vy_q;
  logic                    vw_neg_q;
  logic signed [LO_P_W-1:0] aw_q;
  logic signed [SX_W-1:0]  sxp_q;
  logic signed [SX_W-1:0]  sxm_q;

  logic [OP_W-1:0]     op_q;
  logic [MUL_B_W-1:0]  mulb_q;
  logic [LO_P_W-1:0]   prod_lo_q;
  logic                scale_q;
  logic [WIDX_W-1:0]   widx_q;
  logic [MAG_W-1:0]    mag_q [NUM_WHEELS];
  logic [NUM_WHEELS-1:0] sgn_q;
  logic [MAG_W-1:0]    peak_q;

  logic [WHEEL_W-1:0]  setp_q [NUM_WHEELS];
  logic [IDLE_W-1:0]   idle_q;
  logic                limited_q;
  logic                expired_q;

  logic                res_valid_q;
  logic [WHEEL_W-1:0]  out_w_q [NUM_WHEELS];
  logic                out_lim_q;
  logic                out_to_q;

  logic                cmd_fire;
  logic                res_fire;
  logic [OP_HI_W-1:0]  mul_a;
  logic [MUL_P_W-1:0]  mul_p;
  logic [PROD_W-1:0]   full;
  logic                aw_pos;
  logic signed [SX_W-1:0]  sx_sel;
  logic signed [SUM_W-1:0] aw_ext;
  logic signed [SUM_W-1:0] sx_ext;
  logic signed [SUM_W-1:0] sum;
  logic [SUM_W-1:0]    sum_abs;
  logic [IDLE_W-1:0]   idle_d;
  logic [VEL_W-1:0]    yaw_abs;
  logic [WHEEL_W-1:0]  quot_ext;
  logic [WHEEL_W-1:0]  res_mag [NUM_WHEELS];
  div_req_t            div_req;
  div_rsp_t            div_rsp;

  assign cmd_fire = cmd_chan_i.valid && cmd_chan_i.ready;
  assign res_fire = res_chan_o.valid && res_chan_o.ready;
  assign cmd_chan_i.ready = (state_q == ST_IDLE);

  assign mul_a = (state_q == ST_MHI) ? op_q[OP_W-1:OP_LO_W] : {1'b0, op_q[OP_LO_W-1:0]};
  assign mul_p = {{MUL_B_W{1'b0}}, mul_a} * {{OP_HI_W{1'b0}}, mulb_q};
  assign full  = {mul_p, {OP_LO_W{1'b0}}} + {{(PROD_W-LO_P_W){1'b0}}, prod_lo_q};

  assign aw_pos  = (widx_q[0] == widx_q[1]);
  assign sx_sel  = widx_q[0] ? sxm_q : sxp_q;
  assign aw_ext  = {{(SUM_W-LO_P_W){aw_q[LO_P_W-1]}}, aw_q};
  assign sx_ext  = {{(SUM_W-SX_W-ARM_FRAC_BITS){sx_sel[SX_W-1]}}, sx_sel,
                    {ARM_FRAC_BITS{1'b0}}};
  assign sum     = aw_pos ? (sx_ext + aw_ext) : (sx_ext - aw_ext);
  assign sum_abs = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);

  assign idle_d   = (idle_q == '1) ? idle_q : idle_q + 1'b1;
  assign yaw_abs  = cmd_chan_i.yaw_rate[VEL_W-1] ? VEL_W'(-cmd_chan_i.yaw_rate)
                                                 : VEL_W'(cmd_chan_i.yaw_rate);
  assign quot_ext = {{(WHEEL_W-QUO_W){1'b0}}, div_rsp.quot};

  assign div_req.start = (state_q == ST_MHI) && scale_q;
  assign div_req.num   = full[NUM_W-1:0];
  assign div_req.den   = peak_q;

  mwsl_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arm_q     <= ARM_RESET;
      radius_q  <= RADIUS_RESET;
      max_q     <= MAX_RESET;
      timeout_q <= TIMEOUT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_ARM_LENGTH: arm_q     <= cfg_data_i;
        REG_INV_RADIUS: radius_q  <= cfg_data_i;
        REG_MAX_SPEED:  max_q     <= cfg_data_i[LIM_W-1:0];
        REG_TIMEOUT:    timeout_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      vx_q        <= '0;
      vy_q        <= '0;
      vw_neg_q    <= 1'b0;
      aw_q        <= '0;
      sxp_q       <= '0;
      sxm_q       <= '0;
      op_q        <= '0;
      mulb_q      <= '0;
      prod_lo_q   <= '0;
      scale_q     <= 1'b0;
      widx_q      <= '0;
      sgn_q       <= '0;
      peak_q      <= '0;
      idle_q      <= '0;
      limited_q   <= 1'b0;
      expired_q   <= 1'b0;
      res_valid_q <= 1'b0;
      out_lim_q   <= 1'b0;
      out_to_q    <= 1'b0;
      for (int i = 0; i < NUM_WHEELS; i++) begin
        mag_q[i]   <= '0;
        setp_q[i]  <= '0;
        out_w_q[i] <= '0;
      end
    end else begin
      if (res_fire && state_q != ST_DONE) begin
        res_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (cmd_fire) begin
            limited_q <= 1'b0;
            if (cmd_e'(cmd_chan_i.cmd) == CMD_TICK) begin
              state_q <= ST_TICK;
            end else begin
              vx_q      <= cmd_chan_i.vel_x;
              vy_q      <= cmd_chan_i.vel_y;
              vw_neg_q  <= cmd_chan_i.yaw_rate[VEL_W-1];
              op_q      <= {{(OP_W-VEL_W){1'b0}}, yaw_abs};
              mulb_q    <= arm_q;
              scale_q   <= 1'b0;
              idle_q    <= '0;
              expired_q <= 1'b0;
              state_q   <= ST_AW;
            end
          end
        end
        ST_TICK: begin
          idle_q <= idle_d;
          if (idle_d > {{(IDLE_W-CFG_W){1'b0}}, timeout_q}) begin
            expired_q <= 1'b1;
            for (int i = 0; i < NUM_WHEELS; i++) begin
              setp_q[i] <= '0;
            end
          end else begin
            expired_q <= 1'b0;
          end
          state_q <= ST_DONE;
        end
        ST_AW: begin
          aw_q    <= vw_neg_q ? -$signed(mul_p[LO_P_W-1:0]) : $signed(mul_p[LO_P_W-1:0]);
          sxp_q   <= SX_W'(vx_q) + SX_W'(vy_q);
          sxm_q   <= SX_W'(vx_q) - SX_W'(vy_q);
          mulb_q  <= radius_q;
          peak_q  <= '0;
          widx_q  <= '0;
          state_q <= ST_SUM;
        end
        ST_SUM: begin
          op_q          <= sum_abs[OP_W-1:0];
          sgn_q[widx_q] <= sum[SUM_W-1] ^ aw_pos;
          state_q       <= ST_MLO;
        end
        ST_MLO: begin
          prod_lo_q <= mul_p[LO_P_W-1:0];
          state_q   <= ST_MHI;
        end
        ST_MHI: begin
          if (scale_q) begin
            state_q <= ST_DIV;
          end else begin
            mag_q[widx_q] <= full[PROD_W-1:SHIFT_W];
            widx_q        <= widx_q + 1'b1;
            state_q       <= (widx_q == WIDX_W'(NUM_WHEELS - 1)) ? ST_PEAK : ST_SUM;
          end
        end
        ST_PEAK: begin
          if (mag_q[widx_q] > peak_q) begin
            peak_q <= mag_q[widx_q];
          end
          widx_q <= widx_q + 1'b1;
          if (widx_q == WIDX_W'(NUM_WHEELS - 1)) begin
            state_q <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (peak_q > {{(MAG_W-LIM_W){1'b0}}, max_q}) begin
            limited_q <= 1'b1;
            widx_q    <= '0;
            state_q   <= ST_SLOAD;
          end else begin
            for (int i = 0; i < NUM_WHEELS; i++) begin
              setp_q[i] <= sgn_q[i] ? (~mag_q[i][WHEEL_W-1:0] + 1'b1)
                                    : mag_q[i][WHEEL_W-1:0];
            end
            state_q <= ST_DONE;
          end
        end
        ST_SLOAD: begin
          op_q    <= {{(OP_W-MAG_W){1'b0}}, mag_q[widx_q]};
          mulb_q  <= {{(MUL_B_W-LIM_W){1'b0}}, max_q};
          scale_q <= 1'b1;
          state_q <= ST_MLO;
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            setp_q[widx_q] <= sgn_q[widx_q] ? (~quot_ext + 1'b1) : quot_ext;
            widx_q         <= widx_q + 1'b1;
            state_q        <= (widx_q == WIDX_W'(NUM_WHEELS - 1)) ? ST_DONE : ST_SLOAD;
          end
        end
        ST_DONE: begin
          if (!res_valid_q || res_chan_o.ready) begin
            res_valid_q <= 1'b1;
            out_lim_q   <= limited_q;
            out_to_q    <= expired_q;
            for (int i = 0; i < NUM_WHEELS; i++) begin
              out_w_q[i] <= setp_q[i];
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign res_chan_o.valid         = res_valid_q;
  assign res_chan_o.wheel_speed_0 = out_w_q[0];
  assign res_chan_o.wheel_speed_1 = out_w_q[1];
  assign res_chan_o.wheel_speed_2 = out_w_q[2];
  assign res_chan_o.wheel_speed_3 = out_w_q[3];
  assign res_chan_o.was_limited   = out_lim_q;
  assign res_chan_o.timed_out     = out_to_q;

  always_comb begin
    for (int i = 0; i < NUM_WHEELS; i++) begin
      res_mag[i] = out_w_q[i][WHEEL_W-1] ? (~out_w_q[i] + 1'b1) : out_w_q[i];
    end
  end

  a_limited_within_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && out_lim_q |->
      res_mag[0] <= WHEEL_W'(max_q) && res_mag[1] <= WHEEL_W'(max_q) &&
      res_mag[2] <= WHEEL_W'(max_q) && res_mag[3] <= WHEEL_W'(max_q))
    else $error("limited result exceeds the speed limit");

  a_timeout_zeroes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && out_to_q |->
      !out_lim_q && out_w_q[0] == '0 && out_w_q[1] == '0 &&
      out_w_q[2] == '0 && out_w_q[3] == '0)
    else $error("timed out result carries nonzero speeds or a limit flag");

  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy && state_q == ST_MHI)
    else $error("divider started while busy");

  a_peak_is_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CHECK |->
      peak_q >= mag_q[0] && peak_q >= mag_q[1] &&
      peak_q >= mag_q[2] && peak_q >= mag_q[3])
    else $error("peak magnitude below a wheel magnitude");

endmodule

// ----- rtl/core/mwsl_divider.sv -----
// Restoring radix-2 divider that produces one quotient bit per cycle.
module mwsl_divider (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mwsl_pkg::div_req_t req_i,
  output mwsl_pkg::div_rsp_t rsp_o
);
  import mwsl_pkg::*;

  logic [MAG_W-1:0] rem_q;
  logic [MAG_W-1:0] den_q;
  logic [QUO_W-1:0] quo_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [MAG_W:0]   trial;
  logic [MAG_W:0]   diff;
  logic             fits;

  assign trial = {rem_q, quo_q[QUO_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = ~diff[MAG_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(QUO_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= req_i.num[NUM_W-1:QUO_W];
      quo_q <= req_i.num[QUO_W-1:0];
      den_q <= req_i.den;
    end else if (busy_q) begin
      rem_q <= fits ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
      quo_q <= {quo_q[QUO_W-2:0], fits};
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;

endmodule
